@@ rtl/core/pesw_pkg.sv @@
// Shared types and constants of the particle Euler step unit.
// Holds field widths, command codes, datapath op codes, FSM states and the
// controller/datapath/configuration structs. No dependencies.
package pesw_pkg;

    localparam int POS_W  = 21;
    localparam int DIR_W  = 16;
    localparam int SPD_W  = 24;
    localparam int DT_W   = 16;
    localparam int WALL_W = 12;
    localparam int DAMP_W = 17;
    localparam int GRAV_W = 24;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GRAV = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DAMP   = 2'd2;
    localparam logic [1:0] REG_GRAV   = 2'd3;

    localparam logic [WALL_W-1:0] WIDTH_RST  = 12'd800;
    localparam logic [WALL_W-1:0] HEIGHT_RST = 12'd600;
    localparam logic [DAMP_W-1:0] DAMP_RST   = 17'd64225;
    localparam logic [GRAV_W-1:0] GRAV_RST   = 24'd2509;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_CLAMP,
        OP_MUL_DAMP,
        OP_WR_DAMP,
        OP_MUL_GDT,
        OP_WR_GDT,
        OP_MUL_DXDT,
        OP_MUL_DYDT,
        OP_MUL_SPROD,
        OP_ACC_X,
        OP_ACC_Y,
        OP_POS_X,
        OP_POS_Y,
        OP_MUL_SDX,
        OP_WR_VX,
        OP_MUL_SDY,
        OP_WR_VY,
        OP_MUL_VXX,
        OP_WR_SQ,
        OP_MUL_VYY,
        OP_ADD_SQ,
        OP_SQRT_STEP,
        OP_SPEED,
        OP_DIV_INIT_X,
        OP_DIV_INIT_Y,
        OP_DIV_STEP,
        OP_DIR_X,
        OP_DIR_Y
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MDAMP,
        ST_WDAMP,
        ST_MGDT,
        ST_WGDT,
        ST_MDXDT,
        ST_MSX,
        ST_ACCX,
        ST_POSX,
        ST_MDYDT,
        ST_MSY,
        ST_ACCY,
        ST_POSY,
        ST_MSDX,
        ST_WVX,
        ST_MSDY,
        ST_WVY,
        ST_MVXX,
        ST_WSQ,
        ST_MVYY,
        ST_ADDSQ,
        ST_SQRT,
        ST_SPEED,
        ST_DIVX_INIT,
        ST_DIVX,
        ST_DIRX,
        ST_DIVY_INIT,
        ST_DIVY,
        ST_DIRY,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             mag_zero;
    } dp_status_t;

    typedef struct packed {
        logic [WALL_W-1:0] width;
        logic [WALL_W-1:0] height;
        logic [DAMP_W-1:0] damp;
        logic [GRAV_W-1:0] grav;
    } cfg_t;

    typedef struct packed {
        logic [SPD_W-1:0]        speed;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
        logic [DT_W-1:0]         dt;
    } item_t;

    typedef struct packed {
        logic                    gravity_mode;
        logic                    hit_wall;
        logic [SPD_W-1:0]        speed;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } result_t;

endpackage

@@ rtl/core/pesw_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on pesw_pkg for register indexes, widths and reset values.
module pesw_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pesw_pkg::ADDR_W-1:0] paddr,
    input  logic [pesw_pkg::DATA_W-1:0] pwdata,
    output logic [pesw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pesw_pkg::cfg_t              cfg
);
    import pesw_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_WIDTH:  cfg_next.width  = pwdata[WALL_W-1:0];
                REG_HEIGHT: cfg_next.height = pwdata[WALL_W-1:0];
                REG_DAMP:   cfg_next.damp   = pwdata[DAMP_W-1:0];
                REG_GRAV:   cfg_next.grav   = pwdata[GRAV_W-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = {{(DATA_W-WALL_W){1'b0}}, cfg_reg.width};
            REG_HEIGHT: prdata = {{(DATA_W-WALL_W){1'b0}}, cfg_reg.height};
            REG_DAMP:   prdata = {{(DATA_W-DAMP_W){1'b0}}, cfg_reg.damp};
            REG_GRAV:   prdata = {{(DATA_W-GRAV_W){1'b0}}, cfg_reg.grav};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= WIDTH_RST;
            cfg_reg.height <= HEIGHT_RST;
            cfg_reg.damp   <= DAMP_RST;
            cfg_reg.grav   <= GRAV_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/pesw_ctrl.sv @@
// Sequencing state machine: steps the datapath through clamp, integrate,
// root and divide phases and drives both stream handshakes. Uses pesw_pkg.
module pesw_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pesw_pkg::CMD_W-1:0] s_cmd,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  pesw_pkg::dp_status_t       status,
    output pesw_pkg::dp_cmd_t          dp_cmd
);
    import pesw_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic       accept;
    logic       is_step;

    assign accept  = s_tvalid && s_tready;
    assign is_step = (s_cmd == CMD_STEP) || (s_cmd == CMD_GRAV);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = is_step ? ST_CLAMP : ST_OUT;
                end
            end
            ST_CLAMP:  state_next = ST_MDAMP;
            ST_MDAMP:  state_next = ST_WDAMP;
            ST_WDAMP:  state_next = ST_MGDT;
            ST_MGDT:   state_next = ST_WGDT;
            ST_WGDT:   state_next = ST_MDXDT;
            ST_MDXDT:  state_next = ST_MSX;
            ST_MSX:    state_next = ST_ACCX;
            ST_ACCX:   state_next = ST_POSX;
            ST_POSX:   state_next = ST_MDYDT;
            ST_MDYDT:  state_next = ST_MSY;
            ST_MSY:    state_next = ST_ACCY;
            ST_ACCY:   state_next = ST_POSY;
            ST_POSY:   state_next = (status.cmd == CMD_GRAV) ? ST_MSDX : ST_OUT;
            ST_MSDX:   state_next = ST_WVX;
            ST_WVX:    state_next = ST_MSDY;
            ST_MSDY:   state_next = ST_WVY;
            ST_WVY:    state_next = ST_MVXX;
            ST_MVXX:   state_next = ST_WSQ;
            ST_WSQ:    state_next = ST_MVYY;
            ST_MVYY:   state_next = ST_ADDSQ;
            ST_ADDSQ: begin
                state_next = ST_SQRT;
                cnt_next   = '0;
            end
            ST_SQRT: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED:  state_next = status.mag_zero ? ST_OUT : ST_DIVX_INIT;
            ST_DIVX_INIT: begin
                state_next = ST_DIVX;
                cnt_next   = '0;
            end
            ST_DIVX: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) begin
                    state_next = ST_DIRX;
                end
            end
            ST_DIRX:   state_next = ST_DIVY_INIT;
            ST_DIVY_INIT: begin
                state_next = ST_DIVY;
                cnt_next   = '0;
            end
            ST_DIVY: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) begin
                    state_next = ST_DIRY;
                end
            end
            ST_DIRY:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        dp_cmd.op = OP_IDLE;
        unique case (state_reg)
            ST_IDLE:      dp_cmd.op = accept ? OP_ACCEPT : OP_IDLE;
            ST_CLAMP:     dp_cmd.op = OP_CLAMP;
            ST_MDAMP:     dp_cmd.op = OP_MUL_DAMP;
            ST_WDAMP:     dp_cmd.op = OP_WR_DAMP;
            ST_MGDT:      dp_cmd.op = OP_MUL_GDT;
            ST_WGDT:      dp_cmd.op = OP_WR_GDT;
            ST_MDXDT:     dp_cmd.op = OP_MUL_DXDT;
            ST_MSX:       dp_cmd.op = OP_MUL_SPROD;
            ST_ACCX:      dp_cmd.op = OP_ACC_X;
            ST_POSX:      dp_cmd.op = OP_POS_X;
            ST_MDYDT:     dp_cmd.op = OP_MUL_DYDT;
            ST_MSY:       dp_cmd.op = OP_MUL_SPROD;
            ST_ACCY:      dp_cmd.op = OP_ACC_Y;
            ST_POSY:      dp_cmd.op = OP_POS_Y;
            ST_MSDX:      dp_cmd.op = OP_MUL_SDX;
            ST_WVX:       dp_cmd.op = OP_WR_VX;
            ST_MSDY:      dp_cmd.op = OP_MUL_SDY;
            ST_WVY:       dp_cmd.op = OP_WR_VY;
            ST_MVXX:      dp_cmd.op = OP_MUL_VXX;
            ST_WSQ:       dp_cmd.op = OP_WR_SQ;
            ST_MVYY:      dp_cmd.op = OP_MUL_VYY;
            ST_ADDSQ:     dp_cmd.op = OP_ADD_SQ;
            ST_SQRT:      dp_cmd.op = OP_SQRT_STEP;
            ST_SPEED:     dp_cmd.op = OP_SPEED;
            ST_DIVX_INIT: dp_cmd.op = OP_DIV_INIT_X;
            ST_DIVX:      dp_cmd.op = OP_DIV_STEP;
            ST_DIRX:      dp_cmd.op = OP_DIR_X;
            ST_DIVY_INIT: dp_cmd.op = OP_DIV_INIT_Y;
            ST_DIVY:      dp_cmd.op = OP_DIV_STEP;
            ST_DIRY:      dp_cmd.op = OP_DIR_Y;
            ST_OUT:       dp_cmd.op = OP_IDLE;
            default:      dp_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/core/pesw_dp.sv @@
// Datapath: particle state, one shared 33x33 multiplier, bit-serial square
// root and radix-2 divider, all stepped by op codes. Uses pesw_pkg.
module pesw_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pesw_pkg::dp_cmd_t          dp_cmd,
    output pesw_pkg::dp_status_t       status,
    input  logic [pesw_pkg::CMD_W-1:0] in_cmd,
    input  pesw_pkg::item_t            item,
    input  pesw_pkg::cfg_t             cfg,
    output pesw_pkg::result_t          result
);
    import pesw_pkg::*;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [DT_W-1:0]         dt_reg, dt_next;
    logic signed [POS_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [DIR_W-1:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic [SPD_W-1:0]        speed_reg, speed_next;
    logic                    hit_reg, hit_next, grav_reg, grav_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [39:0]             gdt_reg, gdt_next;
    logic signed [57:0]      acc_reg, acc_next;
    logic signed [30:0]      vx_reg, vx_next, vy_reg, vy_next;
    logic [63:0]             sq_reg, sq_next, sqv_reg, sqv_next;
    logic [63:0]             root_reg, root_next, bit_reg, bit_next;
    logic [15:0]             lo_reg, lo_next, quo_reg, quo_next;
    logic [32:0]             rem_reg, rem_next;
    logic                    neg_reg, neg_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    mul_en;
    logic signed [POS_W-1:0] wx, wy;
    logic                    x_out, y_out;
    logic [41:0]             damp_sum;
    logic signed [57:0]      acc_rnd;
    logic signed [27:0]      step_d;
    logic signed [28:0]      pos_sum;
    logic signed [POS_W-1:0] pos_cur;
    logic signed [POS_W-1:0] pos_sat;
    logic signed [41:0]      v_rnd;
    logic signed [31:0]      v_sh;
    logic [40:0]             g_rnd;
    logic [63:0]             trial;
    logic [32:0]             spd_sum;
    logic signed [30:0]      n_sel;
    logic [29:0]             n_abs;
    logic [47:0]             num;
    logic [32:0]             dvs;
    logic [33:0]             t_div;
    logic                    t_ge;
    logic signed [DIR_W-1:0] q_dir;

    function automatic logic signed [DIR_W-1:0] neg_dir(input logic signed [DIR_W-1:0] d);
        if (d == {1'b1, {(DIR_W-1){1'b0}}}) begin
            return {1'b0, {(DIR_W-1){1'b1}}};
        end
        return -d;
    endfunction

    assign status.cmd      = cmd_reg;
    assign status.mag_zero = (root_reg == 64'd0);

    assign result.pos_x        = pos_x_reg;
    assign result.pos_y        = pos_y_reg;
    assign result.dir_x        = dir_x_reg;
    assign result.dir_y        = dir_y_reg;
    assign result.speed        = speed_reg;
    assign result.hit_wall     = hit_reg;
    assign result.gravity_mode = grav_reg;

    // shared multiplier operands
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (dp_cmd.op)
            OP_MUL_DAMP: begin
                mul_a = $signed({9'd0, speed_reg});
                mul_b = $signed({16'd0, cfg.damp});
            end
            OP_MUL_GDT: begin
                mul_a = $signed({9'd0, cfg.grav});
                mul_b = $signed({17'd0, dt_reg});
            end
            OP_MUL_DXDT: begin
                mul_a = MUL_W'(dir_x_reg);
                mul_b = $signed({17'd0, dt_reg});
            end
            OP_MUL_DYDT: begin
                mul_a = MUL_W'(dir_y_reg);
                mul_b = $signed({17'd0, dt_reg});
            end
            OP_MUL_SPROD: begin
                mul_a = $signed({9'd0, speed_reg});
                mul_b = prod_reg[MUL_W-1:0];
            end
            OP_MUL_SDX: begin
                mul_a = $signed({9'd0, speed_reg});
                mul_b = MUL_W'(dir_x_reg);
            end
            OP_MUL_SDY: begin
                mul_a = $signed({9'd0, speed_reg});
                mul_b = MUL_W'(dir_y_reg);
            end
            OP_MUL_VXX: begin
                mul_a = MUL_W'(vx_reg);
                mul_b = MUL_W'(vx_reg);
            end
            OP_MUL_VYY: begin
                mul_a = MUL_W'(vy_reg);
                mul_b = MUL_W'(vy_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        wx      = $signed({1'b0, cfg.width, 8'h00});
        wy      = $signed({1'b0, cfg.height, 8'h00});
        x_out   = pos_x_reg[POS_W-1] || (pos_x_reg > wx);
        y_out   = pos_y_reg[POS_W-1] || (pos_y_reg > wy);
        damp_sum = {1'b0, prod_reg[40:0]} + 42'd32768;
        acc_rnd = acc_reg + 58'sd536870912;
        step_d  = acc_rnd[57:30];
        pos_cur = (dp_cmd.op == OP_POS_Y) ? pos_y_reg : pos_x_reg;
        pos_sum = 29'(pos_cur) + 29'(step_d);
        if (pos_sum > 29'sd1048575) begin
            pos_sat = {1'b0, {(POS_W-1){1'b1}}};
        end else if (pos_sum < -29'sd1048576) begin
            pos_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pos_sat = pos_sum[POS_W-1:0];
        end
        v_rnd   = prod_reg[41:0] + 42'sd512;
        v_sh    = v_rnd[41:10];
        g_rnd   = {1'b0, gdt_reg} + 41'd2048;
        trial   = root_reg + bit_reg;
        spd_sum = {1'b0, root_reg[31:0]} + 33'd8;
        n_sel   = (dp_cmd.op == OP_DIV_INIT_Y) ? vy_reg : vx_reg;
        n_abs   = n_sel[30] ? 30'(-n_sel) : n_sel[29:0];
        num     = {3'd0, n_abs, 15'd0} + {17'd0, root_reg[30:0]};
        dvs     = {root_reg[31:0], 1'b0};
        t_div   = {rem_reg, lo_reg[15]};
        t_ge    = (t_div >= {1'b0, dvs});
        q_dir   = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

    always_comb begin
        cmd_next   = cmd_reg;
        dt_next    = dt_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        dir_x_next = dir_x_reg;
        dir_y_next = dir_y_reg;
        speed_next = speed_reg;
        hit_next   = hit_reg;
        grav_next  = grav_reg;
        prod_next  = mul_en ? mul_a * mul_b : prod_reg;
        gdt_next   = gdt_reg;
        acc_next   = acc_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        sq_next    = sq_reg;
        sqv_next   = sqv_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        unique case (dp_cmd.op)
            OP_ACCEPT: begin
                cmd_next = in_cmd;
                dt_next  = item.dt;
                hit_next = 1'b0;
                if (in_cmd == CMD_LOAD) begin
                    pos_x_next = item.pos_x;
                    pos_y_next = item.pos_y;
                    dir_x_next = item.dir_x;
                    dir_y_next = item.dir_y;
                    speed_next = item.speed;
                end
            end
            OP_CLAMP: begin
                grav_next = (cmd_reg == CMD_GRAV);
                hit_next  = x_out || y_out;
                if (x_out) begin
                    pos_x_next = pos_x_reg[POS_W-1] ? '0 : wx;
                    dir_x_next = neg_dir(dir_x_reg);
                end
                if (y_out) begin
                    pos_y_next = pos_y_reg[POS_W-1] ? '0 : wy;
                    dir_y_next = neg_dir(dir_y_reg);
                end
            end
            OP_WR_DAMP: begin
                if (hit_reg) begin
                    speed_next = (damp_sum[41:40] != 2'd0) ? {SPD_W{1'b1}}
                                                           : damp_sum[39:16];
                end
            end
            OP_WR_GDT: gdt_next = prod_reg[39:0];
            OP_ACC_X:  acc_next = prod_reg[57:0];
            OP_ACC_Y: begin
                acc_next = prod_reg[57:0];
                if (cmd_reg == CMD_GRAV) begin
                    acc_next = prod_reg[57:0] + $signed({4'd0, gdt_reg, 14'd0});
                end
            end
            OP_POS_X:  pos_x_next = pos_sat;
            OP_POS_Y:  pos_y_next = pos_sat;
            OP_WR_VX:  vx_next = v_sh[30:0];
            OP_WR_VY:  vy_next = v_sh[30:0] + $signed({2'd0, g_rnd[40:12]});
            OP_WR_SQ:  sq_next = prod_reg[63:0];
            OP_ADD_SQ: begin
                sqv_next  = sq_reg + prod_reg[63:0];
                root_next = '0;
                bit_next  = 64'd1 << 62;
            end
            OP_SQRT_STEP: begin
                if (sqv_reg >= trial) begin
                    sqv_next  = sqv_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            OP_SPEED: begin
                if (root_reg == 64'd0) begin
                    dir_x_next = '0;
                    dir_y_next = '0;
                    speed_next = '0;
                end else begin
                    speed_next = (spd_sum[32:28] != 5'd0) ? {SPD_W{1'b1}}
                                                          : spd_sum[27:4];
                end
            end
            OP_DIV_INIT_X, OP_DIV_INIT_Y: begin
                neg_next = n_sel[30];
                rem_next = {1'b0, num[47:16]};
                lo_next  = num[15:0];
                quo_next = '0;
            end
            OP_DIV_STEP: begin
                lo_next  = {lo_reg[14:0], 1'b0};
                quo_next = {quo_reg[14:0], t_ge};
                rem_next = t_ge ? 33'(t_div - {1'b0, dvs}) : t_div[32:0];
            end
            OP_DIR_X:  dir_x_next = q_dir;
            OP_DIR_Y:  dir_y_next = q_dir;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            speed_reg <= '0;
            hit_reg   <= 1'b0;
            grav_reg  <= 1'b0;
            cmd_reg   <= CMD_LOAD;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            dir_x_reg <= dir_x_next;
            dir_y_reg <= dir_y_next;
            speed_reg <= speed_next;
            hit_reg   <= hit_next;
            grav_reg  <= grav_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg   <= dt_next;
        prod_reg <= prod_next;
        gdt_reg  <= gdt_next;
        acc_reg  <= acc_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        sq_reg   <= sq_next;
        sqv_reg  <= sqv_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        lo_reg   <= lo_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
    end

endmodule

@@ rtl/core/particle_euler_step_with_wall_bounce_unit.sv @@
// One particle in a walled box, advanced one Euler step per step or gravity
// step beat. A beat is taken only while the unit is idle, and its result beat
// is held until taken. Load and unused commands go straight to the result
// beat; a plain step runs wall clamp, damping and the position update; a gravity
// step also rebuilds speed and direction with a bit-serial square root and,
// unless the root is zero, two radix-2 dividers; all share one 33x33 multiplier.
// Depends on pesw_pkg, pesw_regs, pesw_ctrl and pesw_dp.
module particle_euler_step_with_wall_bounce_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // dt[15:0] pos_x[36:16] pos_y[57:37] dir_x[73:58] dir_y[89:74] speed[113:90]
    input  logic [119:0]                s_tdata,
    // command[1:0]
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pos_x[20:0] pos_y[41:21] dir_x[57:42] dir_y[73:58] speed[97:74]
    output logic [103:0]                m_tdata,
    // hit_wall[0] gravity_mode[1]
    output logic [1:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pesw_pkg::ADDR_W-1:0] paddr,
    input  logic [pesw_pkg::DATA_W-1:0] pwdata,
    output logic [pesw_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import pesw_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t status;
    item_t      item;
    result_t    result;

    assign item = s_tdata[113:0];
    assign m_tdata = {6'd0, result.speed, result.dir_y, result.dir_x,
                      result.pos_y, result.pos_x};
    assign m_tuser = {result.gravity_mode, result.hit_wall};

    pesw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pesw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    pesw_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dp_cmd  (dp_cmd),
        .status  (status),
        .in_cmd  (s_tuser),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides open together");

    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_LOAD) |=> m_tvalid)
        else $error("load beat did not produce a result next cycle");

    a_free_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("unit not idle after result beat");

endmodule
